// ===== hdl/p2hcr_pkg.sv =====
// Package for the pixel-to-hex cube rounding block: widths, register codes,
// reset values and the rounding and saturation helpers. No dependencies.
package p2hcr_pkg;

  localparam int XW     = 16;          // pixel coordinate width
  localparam int SCW    = 16;          // scale register width
  localparam int PW     = XW + SCW + 2; // product width (signed by unsigned, with margin)
  localparam int FW     = PW + 2;      // fractional cube coordinate, Q.16
  localparam int FRAC_BITS = 16;
  localparam int RW     = FW - FRAC_BITS + 1; // rounded coordinate, signed
  localparam int CW     = RW + 1;      // recomputed coordinate, signed
  localparam int ERRW   = FRAC_BITS + 1; // rounding error, up to one half
  localparam int OW     = 16;          // output coordinate width

  localparam int HALF_ONE = 32768;
  localparam int ONE      = 65536;
  localparam int SAT_MAX  = 32767;
  localparam int SAT_MIN  = -32768;

  localparam int IDX_W = 1;
  localparam logic [SCW-1:0] COL_SCALE_RST = 16'd1328;
  localparam logic [SCW-1:0] ROW_SCALE_RST = 16'd766;

  typedef enum logic [IDX_W-1:0] {
    REG_COL_SCALE = 1'b0,
    REG_ROW_SCALE = 1'b1
  } reg_idx_e;

  // which coordinate gets rebuilt from the other two
  typedef enum logic [1:0] {
    FIX_Q = 2'd0,
    FIX_R = 2'd1,
    FIX_S = 2'd2
  } fix_sel_e;

  function automatic logic [FW-1:0] mag_of(logic signed [FW-1:0] f);
    logic signed [FW-1:0] neg;
    neg = -f;
    return f[FW-1] ? FW'(neg) : FW'(f);
  endfunction

  // round to integer, half away from zero
  function automatic logic signed [RW-1:0] round_half(logic signed [FW-1:0] f);
    logic [FW-1:0] mag;
    logic [FW-1:0] sum;
    logic [RW-1:0] rm;
    mag = mag_of(f);
    sum = mag + FW'(HALF_ONE);
    rm  = RW'(sum >> FRAC_BITS);
    return f[FW-1] ? -$signed(rm) : $signed(rm);
  endfunction

  // |round(f)*2^16 - f|, from the fraction of |f|
  function automatic logic [ERRW-1:0] round_err(logic signed [FW-1:0] f);
    logic [FW-1:0] mag;
    logic [FRAC_BITS-1:0] frac;
    mag  = mag_of(f);
    frac = mag[FRAC_BITS-1:0];
    return frac[FRAC_BITS-1] ? ERRW'(ONE) - {1'b0, frac} : {1'b0, frac};
  endfunction

  function automatic logic signed [OW-1:0] sat16(logic signed [CW-1:0] v);
    logic signed [OW-1:0] res;
    if (v > CW'(SAT_MAX)) begin
      res = OW'(SAT_MAX);
    end else if (v < CW'(SAT_MIN)) begin
      res = OW'(SAT_MIN);
    end else begin
      res = OW'(v);
    end
    return res;
  endfunction

endpackage

// ===== hdl/pixel_to_hex_cube_round.sv =====
// Five register stages: input reg, products, fractional coordinates, rounding
// and selection, rebuild and saturation. Throughput: one position per cycle
// while the output accepts; each stage advances when the next is free, so
// bubbles close up while the output waits. Reset clears all valid flags and
// loads the scale registers with their defaults.
// Pixel to pointy-top hex cell in cube coordinates; uses p2hcr_pkg.
module pixel_to_hex_cube_round (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [p2hcr_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [p2hcr_pkg::SCW-1:0]     cfg_data_i,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // pixel_x, pixel_y
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata   // cell_q, cell_r, cell_s
);
  import p2hcr_pkg::*;

  logic [SCW-1:0] col_scale_q, row_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_scale_q <= COL_SCALE_RST;
      row_scale_q <= ROW_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COL_SCALE: col_scale_q <= cfg_data_i;
        REG_ROW_SCALE: row_scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and ready chain
  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // stage 0: input register
  logic signed [XW-1:0] x_q, y_q;
  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      x_q <= $signed(s_axis_tdata[15:0]);
      y_q <= $signed(s_axis_tdata[31:16]);
    end
  end

  // stage 1: x*col_scale and y*row_scale
  logic signed [SCW:0]  col_s, row_s;
  logic signed [PW-1:0] xc_d, yr_d, xc_q, yr_q;
  assign col_s = $signed({1'b0, col_scale_q});
  assign row_s = $signed({1'b0, row_scale_q});
  assign xc_d  = PW'(x_q) * PW'(col_s);
  assign yr_d  = PW'(y_q) * PW'(row_s);

  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      xc_q <= xc_d;
      yr_q <= yr_d;
    end
  end

  // stage 2: fractional cube coordinates, s = -x*c - y*r
  logic signed [FW-1:0] fq_q, fr_q, fs_q;
  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      fq_q <= FW'(xc_q) - FW'(yr_q);
      fr_q <= FW'(yr_q) <<< 1;
      fs_q <= -FW'(xc_q) - FW'(yr_q);
    end
  end

  // stage 3: round each, pick the one with the largest error
  logic [ERRW-1:0]      eq, er, es;
  fix_sel_e             sel_d, sel_q;
  logic signed [RW-1:0] rq_q, rr_q, rs_q;

  assign eq = round_err(fq_q);
  assign er = round_err(fr_q);
  assign es = round_err(fs_q);

  always_comb begin
    if (eq > er && eq > es) begin
      sel_d = FIX_Q;
    end else if (er > es) begin
      sel_d = FIX_R;
    end else begin
      sel_d = FIX_S;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      rq_q  <= round_half(fq_q);
      rr_q  <= round_half(fr_q);
      rs_q  <= round_half(fs_q);
      sel_q <= sel_d;
    end
  end

  // stage 4: rebuild the selected coordinate, saturate
  logic signed [CW-1:0] cq, cr, cs;
  logic signed [OW-1:0] q_q, r_q, s_q;

  always_comb begin
    cq = CW'(rq_q);
    cr = CW'(rr_q);
    cs = CW'(rs_q);
    unique case (sel_q)
      FIX_Q:   cq = -CW'(rr_q) - CW'(rs_q);
      FIX_R:   cr = -CW'(rq_q) - CW'(rs_q);
      FIX_S:   cs = -CW'(rq_q) - CW'(rr_q);
      default: cs = -CW'(rq_q) - CW'(rr_q);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      q_q <= sat16(cq);
      r_q <= sat16(cr);
      s_q <= sat16(cs);
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {s_q, r_q, q_q};

`ifndef NO_ASSERTIONS
  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v0_q)
    else $error("accepted transfer not captured in input stage");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy4 |=> $stable(rq_q) && $stable(rr_q) && $stable(rs_q) && $stable(sel_q))
    else $error("rounding stage changed while stalled");

  a_cube_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && q_q != OW'(SAT_MAX) && q_q != OW'(SAT_MIN) &&
    r_q != OW'(SAT_MAX) && r_q != OW'(SAT_MIN) &&
    s_q != OW'(SAT_MAX) && s_q != OW'(SAT_MIN)
    |-> (18'(q_q) + 18'(r_q) + 18'(s_q)) == 18'sd0)
    else $error("cube coordinates do not sum to zero");
`endif

endmodule
